>>> design/bitmap_glyph_text_renderer_assert.svh
// Assertion macros shared by the renderer modules.
// Each macro samples on clk and is switched off while arst_n is low.
`ifndef BITMAP_GLYPH_TEXT_RENDERER_ASSERT_SVH
`define BITMAP_GLYPH_TEXT_RENDERER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BGTR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("renderer check failed");

// The consequent must hold in the cycle after the antecedent.
`define BGTR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("renderer check failed");

`endif

>>> design/bgtr_pkg.sv
package bgtr_pkg;

	// Field widths of the streams and registers.
	localparam int ADDR_W    = 25;
	localparam int COLOR_W   = 32;
	localparam int DIM_W     = 13;
	localparam int CODE_W    = 8;
	localparam int POS_W     = 12;
	localparam int IDX_W     = 7;
	localparam int CFG_IDX_W = 3;
	localparam int GLYPH_DIM = 8;
	localparam int GLYPH_PIX = GLYPH_DIM * GLYPH_DIM;
	localparam int GLYPH_COUNT = 95;
	localparam int ROM_BYTES = GLYPH_COUNT * GLYPH_DIM;

	// Character codes with a meaning.
	localparam logic [CODE_W-1:0] GLYPH_FIRST  = 8'd32;
	localparam logic [CODE_W-1:0] GLYPH_LAST   = 8'd126;
	localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'd10;

	// Depth of the job queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic {
		OP_PUT_CHAR   = 1'b0,
		OP_SET_CURSOR = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FG_COLOR = 3'd0,
		REG_BG_COLOR = 3'd1,
		REG_FILL     = 3'd2,
		REG_STRIDE   = 3'd3,
		REG_HEIGHT   = 3'd4
	} cfg_reg_t;

	localparam logic [COLOR_W-1:0] FG_RESET     = 32'hFFCCCCCC;
	localparam logic [COLOR_W-1:0] BG_RESET     = 32'hFF1B1B1B;
	localparam logic [DIM_W-1:0]   STRIDE_RESET = 13'd768;
	localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd1280;

	typedef struct packed {
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
		logic               fill_background;
		logic [DIM_W-1:0]   line_stride;
		logic [DIM_W-1:0]   screen_height;
	} cfg_t;

	// One glyph to draw: font index and address of its top-left pixel.
	typedef struct packed {
		logic [IDX_W-1:0]  glyph;
		logic [ADDR_W-1:0] base;
	} job_t;

	// 8x8 font, eight row bytes per glyph, top row first, bit 0 leftmost.
	localparam logic [7:0] GLYPH_ROM [0:ROM_BYTES-1] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h30, 8'h30, 8'h18, 8'h18, 8'h00, 8'h0C, 8'h00,
		8'h00, 8'h22, 8'h22, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h66, 8'h66, 8'hFF, 8'h66, 8'hFF, 8'h66, 8'h66,
		8'h00, 8'h18, 8'h7C, 8'h06, 8'h3C, 8'h60, 8'h3E, 8'h18,
		8'h10, 8'h46, 8'h66, 8'h30, 8'h18, 8'h0C, 8'h66, 8'h62,
		8'h00, 8'h3C, 8'h66, 8'h3C, 8'h1C, 8'hE6, 8'h66, 8'hFC,
		8'h00, 8'h18, 8'h0C, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h30, 8'h18, 8'h0C, 8'h0C, 8'h18, 8'h30, 8'h00,
		8'h00, 8'h0C, 8'h18, 8'h30, 8'h30, 8'h18, 8'h0C, 8'h00,
		8'h00, 8'h66, 8'h3C, 8'hFF, 8'h3C, 8'h66, 8'h00, 8'h00,
		8'h00, 8'h18, 8'h18, 8'h7E, 8'h18, 8'h18, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h18, 8'h18, 8'h0C, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h18, 8'h18, 8'h00,
		8'h00, 8'h40, 8'h60, 8'h30, 8'h18, 8'h0C, 8'h06, 8'h00,
		8'h00, 8'h3C, 8'h66, 8'h76, 8'h6E, 8'h66, 8'h3C, 8'h00,
		8'h00, 8'h18, 8'h1C, 8'h18, 8'h18, 8'h18, 8'h7E, 8'h00,
		8'h00, 8'h3C, 8'h62, 8'h30, 8'h0C, 8'h06, 8'h7E, 8'h00,
		8'h00, 8'h3C, 8'h62, 8'h38, 8'h60, 8'h66, 8'h3C, 8'h00,
		8'h00, 8'h6C, 8'h6C, 8'h66, 8'hFE, 8'h60, 8'h60, 8'h00,
		8'h00, 8'h7E, 8'h06, 8'h7E, 8'h60, 8'h66, 8'h3C, 8'h00,
		8'h00, 8'h3C, 8'h06, 8'h3E, 8'h66, 8'h66, 8'h3C, 8'h00,
		8'h00, 8'h7E, 8'h30, 8'h30, 8'h18, 8'h18, 8'h18, 8'h00,
		8'h00, 8'h3C, 8'h66, 8'h3C, 8'h66, 8'h66, 8'h3C, 8'h00,
		8'h00, 8'h3C, 8'h66, 8'h7C, 8'h60, 8'h66, 8'h3C, 8'h00,
		8'h00, 8'h00, 8'h18, 8'h00, 8'h00, 8'h00, 8'h18, 8'h00,
		8'h00, 8'h00, 8'h18, 8'h00, 8'h18, 8'h18, 8'h0C, 8'h00,
		8'h00, 8'h70, 8'h1C, 8'h06, 8'h06, 8'h1C, 8'h70, 8'h00,
		8'h00, 8'h00, 8'h3E, 8'h00, 8'h3E, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h0E, 8'h38, 8'h60, 8'h60, 8'h38, 8'h0E, 8'h00,
		8'h00, 8'h3C, 8'h66, 8'h30, 8'h18, 8'h00, 8'h18, 8'h00,
		8'h00, 8'h3C, 8'h66, 8'h76, 8'h76, 8'h06, 8'h46, 8'h3C,
		8'h00, 8'h3C, 8'h66, 8'h7E, 8'h66, 8'h66, 8'h66, 8'h00,
		8'h00, 8'h3E, 8'h66, 8'h3E, 8'h66, 8'h66, 8'h3E, 8'h00,
		8'h00, 8'h3C, 8'h66, 8'h06, 8'h06, 8'h66, 8'h3C, 8'h00,
		8'h00, 8'h1E, 8'h36, 8'h66, 8'h66, 8'h36, 8'h1E, 8'h00,
		8'h00, 8'h7E, 8'h06, 8'h1E, 8'h06, 8'h06, 8'h7E, 8'h00,
		8'h00, 8'h3E, 8'h06, 8'h1E, 8'h06, 8'h06, 8'h06, 8'h00,
		8'h00, 8'h3C, 8'h66, 8'h06, 8'h76, 8'h66, 8'h3C, 8'h00,
		8'h00, 8'h66, 8'h66, 8'h7E, 8'h66, 8'h66, 8'h66, 8'h00,
		8'h00, 8'h3C, 8'h18, 8'h18, 8'h18, 8'h18, 8'h3C, 8'h00,
		8'h00, 8'h78, 8'h30, 8'h30, 8'h30, 8'h36, 8'h1C, 8'h00,
		8'h00, 8'h66, 8'h36, 8'h1E, 8'h1E, 8'h36, 8'h66, 8'h00,
		8'h00, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h7E, 8'h00,
		8'h00, 8'h46, 8'h6E, 8'h7E, 8'h56, 8'h46, 8'h46, 8'h00,
		8'h00, 8'h66, 8'h6E, 8'h7E, 8'h76, 8'h66, 8'h66, 8'h00,
		8'h00, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C, 8'h00,
		8'h00, 8'h3E, 8'h66, 8'h3E, 8'h06, 8'h06, 8'h06, 8'h00,
		8'h00, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h3C, 8'h70, 8'h00,
		8'h00, 8'h3E, 8'h66, 8'h3E, 8'h1E, 8'h36, 8'h66, 8'h00,
		8'h00, 8'h3C, 8'h66, 8'h0C, 8'h30, 8'h66, 8'h3C, 8'h00,
		8'h00, 8'h7E, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h00,
		8'h00, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C, 8'h00,
		8'h00, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C, 8'h18, 8'h00,
		8'h00, 8'h46, 8'h46, 8'h56, 8'h7E, 8'h6E, 8'h46, 8'h00,
		8'h00, 8'h66, 8'h3C, 8'h18, 8'h3C, 8'h66, 8'h66, 8'h00,
		8'h00, 8'h66, 8'h66, 8'h3C, 8'h18, 8'h18, 8'h18, 8'h00,
		8'h00, 8'h7E, 8'h30, 8'h18, 8'h0C, 8'h06, 8'h7E, 8'h00,
		8'h00, 8'h3C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h3C,
		8'h00, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'h40, 8'h00,
		8'h00, 8'h3C, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h3C,
		8'h00, 8'h18, 8'h3C, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7E,
		8'h00, 8'h0C, 8'h18, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h3C, 8'h60, 8'h7C, 8'h66, 8'h7C, 8'h00,
		8'h00, 8'h06, 8'h06, 8'h3E, 8'h66, 8'h66, 8'h3E, 8'h00,
		8'h00, 8'h00, 8'h3C, 8'h06, 8'h06, 8'h06, 8'h3C, 8'h00,
		8'h00, 8'h60, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h7C, 8'h00,
		8'h00, 8'h00, 8'h3C, 8'h66, 8'h7E, 8'h06, 8'h3C, 8'h00,
		8'h00, 8'h38, 8'h0C, 8'h3E, 8'h0C, 8'h0C, 8'h0C, 8'h00,
		8'h00, 8'h00, 8'h7C, 8'h66, 8'h7C, 8'h40, 8'h3C, 8'h00,
		8'h00, 8'h06, 8'h06, 8'h3E, 8'h66, 8'h66, 8'h66, 8'h00,
		8'h00, 8'h18, 8'h00, 8'h1C, 8'h18, 8'h18, 8'h3C, 8'h00,
		8'h00, 8'h30, 8'h00, 8'h30, 8'h30, 8'h30, 8'h1E, 8'h00,
		8'h00, 8'h06, 8'h06, 8'h36, 8'h1E, 8'h36, 8'h66, 8'h00,
		8'h00, 8'h1C, 8'h18, 8'h18, 8'h18, 8'h18, 8'h3C, 8'h00,
		8'h00, 8'h00, 8'h66, 8'hFE, 8'hFE, 8'hD6, 8'hC6, 8'h00,
		8'h00, 8'h00, 8'h3E, 8'h66, 8'h66, 8'h66, 8'h66, 8'h00,
		8'h00, 8'h00, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h3C, 8'h00,
		8'h00, 8'h00, 8'h3E, 8'h66, 8'h66, 8'h3E, 8'h06, 8'h00,
		8'h00, 8'h00, 8'h7C, 8'h66, 8'h66, 8'h7C, 8'h60, 8'h00,
		8'h00, 8'h00, 8'h3E, 8'h66, 8'h06, 8'h06, 8'h06, 8'h00,
		8'h00, 8'h00, 8'h7C, 8'h06, 8'h3C, 8'h60, 8'h3E, 8'h00,
		8'h00, 8'h18, 8'h7E, 8'h18, 8'h18, 8'h18, 8'h70, 8'h00,
		8'h00, 8'h00, 8'h66, 8'h66, 8'h66, 8'h66, 8'h7C, 8'h00,
		8'h00, 8'h00, 8'h66, 8'h66, 8'h66, 8'h3C, 8'h18, 8'h00,
		8'h00, 8'h00, 8'hC6, 8'hD6, 8'hFE, 8'h7C, 8'h6C, 8'h00,
		8'h00, 8'h00, 8'h66, 8'h3C, 8'h18, 8'h3C, 8'h66, 8'h00,
		8'h00, 8'h00, 8'h66, 8'h66, 8'h7C, 8'h60, 8'h3C, 8'h00,
		8'h00, 8'h00, 8'h7E, 8'h30, 8'h18, 8'h0C, 8'h7E, 8'h00,
		8'h00, 8'h00, 8'h18, 8'h08, 8'h08, 8'h04, 8'h08, 8'h08,
		8'h00, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
		8'h00, 8'h00, 8'h0C, 8'h08, 8'h08, 8'h10, 8'h08, 8'h08,
		8'h00, 8'h00, 8'h00, 8'h4C, 8'h32, 8'h00, 8'h00, 8'h00
	};

	// Whole glyph as one word: row r sits in bits [8r+7:8r].
	function automatic logic [GLYPH_PIX-1:0] glyph_bits(input logic [IDX_W-1:0] idx);
		logic [GLYPH_PIX-1:0] g;
		g = '0;
		if (idx < IDX_W'(GLYPH_COUNT)) begin
			for (int r = 0; r < GLYPH_DIM; r++) begin
				g[GLYPH_DIM*r +: GLYPH_DIM] = GLYPH_ROM[{idx, 3'(r)}];
			end
		end
		return g;
	endfunction

endpackage

>>> design/bgtr_front.sv
module bgtr_front
	import bgtr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // char_code[7:0], new_x[19:8], new_y[31:20]
	input  logic        s_tuser,   // opcode
	input  cfg_t        cfg,
	input  logic        queue_full,
	output logic        push,
	output job_t        push_job
);

	localparam int CB   = COORD_BITS;
	localparam int CMPW = (CB + 2 > DIM_W + 1) ? CB + 2 : DIM_W + 1;

	logic [CB-1:0]       cursor_x_q;
	logic [CB-1:0]       cursor_y_q;
	logic                accept;
	logic [CODE_W-1:0]   code;
	logic                is_print;
	logic                is_newline;
	logic [CB+DIM_W-1:0] line_prod;
	logic [CB:0]         y_next;
	logic                y_wrap;

	assign s_tready   = !queue_full;
	assign accept     = s_tvalid && s_tready;
	assign code       = s_tdata[7:0];
	assign is_newline = (code == CHAR_NEWLINE);

	always_comb begin
		is_print = code inside {[GLYPH_FIRST:GLYPH_LAST]};
	end

	// Top-left pixel of the glyph at the cursor.
	assign line_prod = cursor_y_q * cfg.line_stride;

	assign push              = accept && (s_tuser == OP_PUT_CHAR) && is_print;
	assign push_job.glyph    = IDX_W'(code - GLYPH_FIRST);
	assign push_job.base     = ADDR_W'(line_prod) + ADDR_W'(cursor_x_q);

	// Next text line, wrapping to the top when it would not fit.
	assign y_next = {1'b0, cursor_y_q} + (CB+1)'(GLYPH_DIM);
	assign y_wrap = y_next[CB] ||
		((CMPW'(y_next) + CMPW'(GLYPH_DIM)) > CMPW'(cfg.screen_height));

	// Cursor updates in transaction order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (accept) begin
			if (s_tuser == OP_SET_CURSOR) begin
				cursor_x_q <= CB'(s_tdata[19:8]);
				cursor_y_q <= CB'(s_tdata[31:20]);
			end else if (is_print) begin
				if (&cursor_x_q[CB-1:3]) begin
					cursor_x_q <= '1;
				end else begin
					cursor_x_q <= cursor_x_q + CB'(GLYPH_DIM);
				end
			end else if (is_newline) begin
				cursor_x_q <= '0;
				cursor_y_q <= y_wrap ? '0 : y_next[CB-1:0];
			end
		end
	end

endmodule

>>> design/bgtr_queue.sv
module bgtr_queue
	import bgtr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic valid,
	output job_t head
);

`include "bitmap_glyph_text_renderer_assert.svh"

	job_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign full  = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	`BGTR_ASSERT_SAME(a_no_push_when_full, push, !full)
	`BGTR_ASSERT_SAME(a_no_pop_when_empty, pop, valid)

endmodule

>>> design/bgtr_raster.sv
module bgtr_raster
	import bgtr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        job_valid,
	input  job_t        job,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // pixel_address[24:0], pixel_color[56:25]
	output logic        m_tlast    // last
);

`include "bitmap_glyph_text_renderer_assert.svh"

	localparam int PIX_W = $clog2(GLYPH_PIX);

	logic                 busy_q;
	logic [GLYPH_PIX-1:0] glyph_q;
	logic [PIX_W-1:0]     pos_q;
	logic [ADDR_W-1:0]    row_addr_q;
	logic                 out_valid_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [COLOR_W-1:0]   color_q;
	logic                 last_q;

	logic can_adv;
	logic step;
	logic rest_empty;
	logic emit;
	logic last;
	logic done;

	// One glyph position per cycle whenever the output register can take it.
	assign can_adv    = !out_valid_q || m_tready;
	assign step       = busy_q && can_adv;
	assign rest_empty = (glyph_q[GLYPH_PIX-1:1] == '0);
	assign emit       = glyph_q[0] || cfg.fill_background;
	assign last       = cfg.fill_background ? (pos_q == '1) : rest_empty;
	assign done       = (pos_q == '1) || (!cfg.fill_background && rest_empty);
	assign pop        = job_valid && (!busy_q || (step && done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (step && done) begin
				busy_q <= 1'b0;
			end
			if (can_adv) begin
				out_valid_q <= step && emit;
			end
		end
	end

	// Glyph shift register and row address walk.
	always_ff @(posedge clk) begin
		if (pop) begin
			glyph_q    <= glyph_bits(job.glyph);
			pos_q      <= '0;
			row_addr_q <= job.base;
		end else if (step) begin
			glyph_q <= glyph_q >> 1;
			pos_q   <= pos_q + 1'b1;
			if (pos_q[2:0] == 3'd7) begin
				row_addr_q <= row_addr_q + ADDR_W'(cfg.line_stride);
			end
		end
	end

	// Output register for the pixel write.
	always_ff @(posedge clk) begin
		if (step && emit) begin
			addr_q  <= row_addr_q + ADDR_W'(pos_q[2:0]);
			color_q <= glyph_q[0] ? cfg.fg_color : cfg.bg_color;
			last_q  <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, color_q, addr_q};
	assign m_tlast  = last_q;

	`BGTR_ASSERT_SAME(a_final_position_ends, step && (pos_q == '1), done)
	`BGTR_ASSERT_NEXT(a_idle_after_done, step && done && !pop, !busy_q)

endmodule

>>> design/bitmap_glyph_text_renderer.sv
// Text console renderer with a fixed 8x8 font. Each input transaction either
// sets the cursor (tuser high) or puts one character code (tuser low). Codes
// 32..126 are drawn at the cursor as framebuffer writes on the output stream
// in row order, left to right, with tlast on the final write of the glyph; a
// newline moves the cursor to the start of the next text line, and other
// codes are dropped. Unless the output stalls, the pixel engine steps one glyph
// position per cycle and writes every pixel with background fill on, or only
// set pixels up to the last set bit with fill off (one position for a blank
// glyph). Cursor moves, newlines and dropped codes stay in the front end and
// run alongside drawing; up to four glyphs wait in a queue, after which the
// input stalls until the pixel engine frees a slot. Output stalls hold the engine.
module bitmap_glyph_text_renderer
	import bgtr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // char_code[7:0], new_x[19:8], new_y[31:20]
	input  logic        s_tuser,    // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,    // pixel_address[24:0], pixel_color[56:25]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg_q;
	logic queue_full;
	logic push;
	job_t push_job;
	logic pop;
	logic job_valid;
	job_t head;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fg_color        <= FG_RESET;
			cfg_q.bg_color        <= BG_RESET;
			cfg_q.fill_background <= 1'b0;
			cfg_q.line_stride     <= STRIDE_RESET;
			cfg_q.screen_height   <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FG_COLOR: cfg_q.fg_color        <= cfg_data;
				REG_BG_COLOR: cfg_q.bg_color        <= cfg_data;
				REG_FILL:     cfg_q.fill_background <= cfg_data[0];
				REG_STRIDE:   cfg_q.line_stride     <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:   cfg_q.screen_height   <= cfg_data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bgtr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg        (cfg_q),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	bgtr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.valid    (job_valid),
		.head     (head)
	);

	bgtr_raster u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job       (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
